// ===== design/trilinear_table_interpolator_macros.svh =====
// Assertion macros used by the interpolator design file.
`ifndef TRILINEAR_TABLE_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_TABLE_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tti_pkg.sv =====
package tti_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_DENSITY_ORIGIN       = 3'd0;
    localparam logic [2:0] REG_DENSITY_INV_STEP     = 3'd1;
    localparam logic [2:0] REG_FRACTION_ORIGIN      = 3'd2;
    localparam logic [2:0] REG_FRACTION_INV_STEP    = 3'd3;
    localparam logic [2:0] REG_TEMPERATURE_ORIGIN   = 3'd4;
    localparam logic [2:0] REG_TEMPERATURE_INV_STEP = 3'd5;

    localparam logic [16:0] WEIGHT_ONE = 17'h10000;
    localparam logic [30:0] STEP_RESET = 31'd65536;

    typedef struct packed {
        logic [10:0] idx;
        logic [16:0] weight;
        logic        clamp;
    } t_axis;

    // Maps an exact Q32.32 axis position onto a cell index and a Q1.16 weight.
    function automatic t_axis tti_locate(input logic signed [63:0] pos,
                                         input logic [10:0] pts);
        t_axis       r;
        logic [31:0] whole;
        logic [31:0] last;
        whole = pos[63:32];
        last  = 32'(pts) - 32'd1;
        r.idx    = 11'd0;
        r.weight = 17'd0;
        r.clamp  = 1'b0;
        if (pos[63]) begin
            r.clamp = 1'b1;
        end else if (whole >= last) begin
            r.idx    = pts - 11'd2;
            r.weight = WEIGHT_ONE;
            r.clamp  = !((whole == last) && (pos[31:0] == 32'd0));
        end else begin
            r.idx    = whole[10:0];
            r.weight = {1'b0, pos[31:16]};
        end
        return r;
    endfunction

    // Linear blend of two entries, rounded to nearest with ties upward.
    function automatic logic signed [31:0] tti_blend(input logic signed [31:0] a,
                                                     input logic signed [31:0] b,
                                                     input logic [16:0] w);
        logic signed [17:0] wa;
        logic signed [17:0] wb;
        logic signed [49:0] s;
        wa = $signed({1'b0, WEIGHT_ONE - w});
        wb = $signed({1'b0, w});
        s  = a * wa + b * wb + 50'sd32768;
        return s[47:16];
    endfunction

endpackage

// ===== design/tti_ram.sv =====
module tti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/trilinear_table_interpolator.sv =====
// Trilinear interpolator over eight tables on a uniform three-axis grid.
// Input channel (i_valid / o_stall) carries one transaction per item: op
// selects a table write or a query. Writes produce no result; each query
// produces one result transaction (o_valid / i_stall) with the blended Q16.16
// value and a flag set when any coordinate lay outside its axis.
// Axis origins and inverse spacings are written over the APB port; the user
// must write them only while the block is idle, which the block itself does not enforce.
// pready is always high and reads return the register value.
// One item is accepted every cycle unless a waiting result is stalled: the eight
// corners come from eight RAM banks split by the parity of the three grid indices,
// each read once. A write lands in its bank in stage 3, the same stage where
// queries read, so item order is kept for every write/query mix.
// When the receiver stalls a waiting result, the whole pipeline freezes and
// o_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and returns the origins to 0 and the inverse
// steps to 1.0. Table contents are undefined until written.
`include "trilinear_table_interpolator_macros.svh"

module trilinear_table_interpolator #(
    parameter int DENSITY_POINTS     = 32,
    parameter int FRACTION_POINTS    = 16,
    parameter int TEMPERATURE_POINTS = 32,
    parameter int QUANTITY_COUNT     = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [2:0]         i_quantity,
    input  logic [4:0]         i_density_slot,
    input  logic [3:0]         i_fraction_slot,
    input  logic [4:0]         i_temperature_slot,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_log_density,
    input  logic signed [31:0] i_charge_fraction,
    input  logic signed [31:0] i_log_temperature,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic               o_clamped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import tti_pkg::*;

    localparam int DCW = $clog2(DENSITY_POINTS);
    localparam int FCW = $clog2(FRACTION_POINTS);
    localparam int TCW = $clog2(TEMPERATURE_POINTS);
    localparam int DHW = (DCW > 1) ? DCW - 1 : 1;
    localparam int FHW = (FCW > 1) ? FCW - 1 : 1;
    localparam int THW = (TCW > 1) ? TCW - 1 : 1;
    localparam int QW  = (QUANTITY_COUNT > 1) ? $clog2(QUANTITY_COUNT) : 1;
    localparam int AW  = QW + DHW + FHW + THW;
    localparam int BANK_DEPTH = 2 ** AW;

    logic signed [31:0] r_dorg, r_forg, r_torg;
    logic [30:0]        r_dinv, r_finv, r_tinv;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dorg <= '0;
            r_forg <= '0;
            r_torg <= '0;
            r_dinv <= STEP_RESET;
            r_finv <= STEP_RESET;
            r_tinv <= STEP_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_DENSITY_ORIGIN:       r_dorg <= pwdata;
                REG_DENSITY_INV_STEP:     r_dinv <= pwdata[30:0];
                REG_FRACTION_ORIGIN:      r_forg <= pwdata;
                REG_FRACTION_INV_STEP:    r_finv <= pwdata[30:0];
                REG_TEMPERATURE_ORIGIN:   r_torg <= pwdata;
                REG_TEMPERATURE_INV_STEP: r_tinv <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DENSITY_ORIGIN:       prdata = r_dorg;
            REG_DENSITY_INV_STEP:     prdata = {1'b0, r_dinv};
            REG_FRACTION_ORIGIN:      prdata = r_forg;
            REG_FRACTION_INV_STEP:    prdata = {1'b0, r_finv};
            REG_TEMPERATURE_ORIGIN:   prdata = r_torg;
            REG_TEMPERATURE_INV_STEP: prdata = {1'b0, r_tinv};
            default:                  prdata = '0;
        endcase
    end

    logic w_adv;
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // Stage 1: offsets from the axis origins.
    logic               r_v1, r_wr1, r_wok1, r_qok1;
    logic [2:0]         r_q1;
    logic [4:0]         r_ds1, r_ts1;
    logic [3:0]         r_fs1;
    logic signed [31:0] r_val1;
    logic signed [32:0] r_dd1, r_fd1, r_td1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wr1  <= (i_op == OP_WRITE);
            r_q1   <= i_quantity;
            r_qok1 <= 5'(i_quantity) < 5'(QUANTITY_COUNT);
            r_wok1 <= (5'(i_quantity) < 5'(QUANTITY_COUNT))
                   && (11'(i_density_slot) < 11'(DENSITY_POINTS))
                   && (11'(i_fraction_slot) < 11'(FRACTION_POINTS))
                   && (11'(i_temperature_slot) < 11'(TEMPERATURE_POINTS));
            r_ds1  <= i_density_slot;
            r_fs1  <= i_fraction_slot;
            r_ts1  <= i_temperature_slot;
            r_val1 <= i_entry_value;
            r_dd1  <= {i_log_density[31], i_log_density} - {r_dorg[31], r_dorg};
            r_fd1  <= {i_charge_fraction[31], i_charge_fraction} - {r_forg[31], r_forg};
            r_td1  <= {i_log_temperature[31], i_log_temperature} - {r_torg[31], r_torg};
        end
    end

    // Stage 2: exact Q32.32 positions on each axis.
    logic               r_v2, r_wr2, r_wok2, r_qok2;
    logic [2:0]         r_q2;
    logic [4:0]         r_ds2, r_ts2;
    logic [3:0]         r_fs2;
    logic signed [31:0] r_val2;
    logic signed [63:0] r_dp2, r_fp2, r_tp2;
    logic signed [64:0] w_dp, w_fp, w_tp;

    assign w_dp = r_dd1 * $signed({1'b0, r_dinv});
    assign w_fp = r_fd1 * $signed({1'b0, r_finv});
    assign w_tp = r_td1 * $signed({1'b0, r_tinv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wr2  <= r_wr1;
            r_wok2 <= r_wok1;
            r_qok2 <= r_qok1;
            r_q2   <= r_q1;
            r_ds2  <= r_ds1;
            r_fs2  <= r_fs1;
            r_ts2  <= r_ts1;
            r_val2 <= r_val1;
            r_dp2  <= w_dp[63:0];
            r_fp2  <= w_fp[63:0];
            r_tp2  <= w_tp[63:0];
        end
    end

    // Stage 3: cells and weights; table access for reads and writes.
    t_axis w_la_d, w_la_f, w_la_t;
    assign w_la_d = tti_locate(r_dp2, 11'(DENSITY_POINTS));
    assign w_la_f = tti_locate(r_fp2, 11'(FRACTION_POINTS));
    assign w_la_t = tti_locate(r_tp2, 11'(TEMPERATURE_POINTS));

    logic               r_v3, r_wr3, r_wok3, r_qok3, r_clamp3;
    logic [2:0]         r_q3;
    logic [4:0]         r_ds3, r_ts3;
    logic [3:0]         r_fs3;
    logic signed [31:0] r_val3;
    logic [DCW-1:0]     r_cd3;
    logic [FCW-1:0]     r_cf3;
    logic [TCW-1:0]     r_ct3;
    logic [16:0]        r_wd3, r_wf3, r_wt3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wr3    <= r_wr2;
            r_wok3   <= r_wok2;
            r_qok3   <= r_qok2;
            r_q3     <= r_q2;
            r_ds3    <= r_ds2;
            r_fs3    <= r_fs2;
            r_ts3    <= r_ts2;
            r_val3   <= r_val2;
            r_cd3    <= DCW'(w_la_d.idx);
            r_cf3    <= FCW'(w_la_f.idx);
            r_ct3    <= TCW'(w_la_t.idx);
            r_wd3    <= w_la_d.weight;
            r_wf3    <= w_la_f.weight;
            r_wt3    <= w_la_t.weight;
            r_clamp3 <= w_la_d.clamp || w_la_f.clamp || w_la_t.clamp;
        end
    end

    logic [AW-1:0] w_waddr;
    logic [2:0]    w_wbank;
    logic [31:0]   w_rd [8];

    assign w_wbank = {r_ds3[0], r_fs3[0], r_ts3[0]};
    assign w_waddr = {QW'(r_q3), DHW'(r_ds3 >> 1), FHW'(r_fs3 >> 1), THW'(r_ts3 >> 1)};

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [AW-1:0] w_raddr;
        logic          w_we;
        logic [DHW-1:0] w_dh;
        logic [FHW-1:0] w_fh;
        logic [THW-1:0] w_th;

        assign w_dh = DHW'((11'(r_cd3) + 11'(r_cd3[0] ^ b[2])) >> 1);
        assign w_fh = FHW'((11'(r_cf3) + 11'(r_cf3[0] ^ b[1])) >> 1);
        assign w_th = THW'((11'(r_ct3) + 11'(r_ct3[0] ^ b[0])) >> 1);
        assign w_raddr = {QW'(r_q3), w_dh, w_fh, w_th};
        assign w_we = w_adv && r_v3 && r_wr3 && r_wok3 && (w_wbank == 3'(b));

        tti_ram #(
            .WIDTH(32),
            .DEPTH(BANK_DEPTH)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we),
            .i_waddr(w_waddr),
            .i_wdata(r_val3),
            .i_re   (w_adv),
            .i_raddr(w_raddr),
            .o_rdata(w_rd[b])
        );
    end

    // Stage 4: corner data from the banks.
    logic        r_v4, r_qok4, r_clamp4;
    logic [2:0]  r_par4;
    logic [16:0] r_wd4, r_wf4, r_wt4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= r_v3 && !r_wr3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qok4   <= r_qok3;
            r_clamp4 <= r_clamp3;
            r_par4   <= {r_cd3[0], r_cf3[0], r_ct3[0]};
            r_wd4    <= r_wd3;
            r_wf4    <= r_wf3;
            r_wt4    <= r_wt3;
        end
    end

    // Stage 5: blend along temperature.
    logic signed [31:0] w_row [4];
    for (genvar r = 0; r < 4; r++) begin : g_row
        logic [2:0] w_lo, w_hi;
        assign w_lo = {r_par4[2] ^ r[1], r_par4[1] ^ r[0], r_par4[0]};
        assign w_hi = {r_par4[2] ^ r[1], r_par4[1] ^ r[0], !r_par4[0]};
        assign w_row[r] = tti_blend(w_rd[w_lo], w_rd[w_hi], r_wt4);
    end

    logic               r_v5, r_qok5, r_clamp5;
    logic [16:0]        r_wd5, r_wf5;
    logic signed [31:0] r_row5 [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qok5   <= r_qok4;
            r_clamp5 <= r_clamp4;
            r_wd5    <= r_wd4;
            r_wf5    <= r_wf4;
            r_row5   <= w_row;
        end
    end

    // Stage 6: blend along charge fraction.
    logic               r_v6, r_qok6, r_clamp6;
    logic [16:0]        r_wd6;
    logic signed [31:0] r_side6 [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_adv) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qok6     <= r_qok5;
            r_clamp6   <= r_clamp5;
            r_wd6      <= r_wd5;
            r_side6[0] <= tti_blend(r_row5[0], r_row5[1], r_wf5);
            r_side6[1] <= tti_blend(r_row5[2], r_row5[3], r_wf5);
        end
    end

    // Stage 7: blend along density into the output register.
    logic               r_vo, r_qoko, r_clampo;
    logic signed [31:0] r_reso;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_adv) begin
            r_vo <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qoko   <= r_qok6;
            r_clampo <= r_clamp6;
            r_reso   <= r_qok6 ? tti_blend(r_side6[0], r_side6[1], r_wd6) : 32'sd0;
        end
    end

    assign o_valid        = r_vo;
    assign o_result_value = r_reso;
    assign o_clamped      = r_clampo;

    `TTI_ASSERT_SAME(a_top_cell, i_clk, i_rst_n, r_v3 && !r_wr3 && r_wd3[16], r_cd3 == DCW'(DENSITY_POINTS - 2), "Full density weight outside the last cell.")
    `TTI_ASSERT_SAME(a_bad_quantity, i_clk, i_rst_n, o_valid && !r_qoko, o_result_value == 32'sd0, "Unknown quantity gave a nonzero result.")
    `TTI_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, o_valid && i_stall, $stable(r_v3) && $stable(r_v5) && $stable(r_vo), "Pipeline moved during an output stall.")

endmodule
